// ===== rtl/core/tsbf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tsbf_pkg: shared types and constants for the timed source block filter
// Beat layouts for the request and response channels, the stored entry
// layout, opcodes and the controller state encoding.
// -----------------------------------------------------------------------------
package tsbf_pkg;

   localparam int TIME_W    = 48;
   localparam int PORT_W    = 8;
   localparam int IP_W      = 32;
   localparam int DUR_W     = 32;
   localparam int DROP_W    = 32;
   localparam int ACTIVE_W  = 5;

   localparam int DEF_TABLE_ENTRIES = 16;

   // opcodes on the request beat
   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_BLOCK = 1'b1;

   typedef struct packed {
      logic              op;
      logic [TIME_W-1:0] now;
      logic [PORT_W-1:0] in_port;
      logic              is_ipv4;
      logic [IP_W-1:0]   src_ip;
      logic [DUR_W-1:0]  duration;
   } req_type;

   typedef struct packed {
      logic                drop;
      logic                lapsed;
      logic                installed;
      logic                table_full;
      logic [ACTIVE_W-1:0] active_entries;
      logic [DROP_W-1:0]   drop_count;
   } rsp_type;

   // one table entry as held in the RAM
   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [IP_W-1:0]   source;
      logic [TIME_W-1:0] expiry;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/tsbf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// tsbf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// -----------------------------------------------------------------------------
module tsbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/timed_source_block_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// timed_source_block_filter: blocked (port, IPv4 source) table with expiry
//
// Request beats carry either a data frame (op = OP_FRAME) or a block command
// (op = OP_BLOCK). Every request beat yields exactly one response beat, in
// order. Table entries (port, source, expiry) live in a RAM; valid bits and
// the entry count live in flops.
// A command or an IPv4 frame scans the RAM one entry per cycle from entry 0,
// stopping at the first matching valid entry, then moves to the apply state.
// A non-IPv4 frame skips the scan and goes straight to the apply state. The
// next request is taken the cycle after the response is loaded; the block
// takes no new request until it is through with the last one, and the
// single RAM read port is why the scan reads one entry at a time.
// The response sits in an output register; a stalled response holds there
// and the block takes one more request, then waits to load its result.
// Reset empties the table at once (valid bits cleared), zeroes the drop
// counter and drops any pending response. No clearing pass is needed.
// -----------------------------------------------------------------------------
module timed_source_block_filter #(
   parameter int TABLE_ENTRIES = tsbf_pkg::DEF_TABLE_ENTRIES
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tsbf_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tsbf_pkg::rsp_type     rsp_data
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int CW    = (CNT_W > tsbf_pkg::ACTIVE_W) ? CNT_W : tsbf_pkg::ACTIVE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   // control state
   tsbf_pkg::state_type        state_ff, state_in;
   logic [TABLE_ENTRIES-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [tsbf_pkg::DROP_W-1:0] drops_ff, drops_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // per-item working registers
   tsbf_pkg::req_type          item_ff, item_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic                       hit_ff, hit_in;
   logic [IDX_W-1:0]           hit_idx_ff, hit_idx_in;
   logic                       expired_ff, expired_in;
   logic                       free_found_ff, free_found_in;
   logic [IDX_W-1:0]           free_idx_ff, free_idx_in;
   tsbf_pkg::rsp_type          rsp_ff, rsp_in;

   // RAM port signals
   logic                       ram_wr_en;
   logic [IDX_W-1:0]           ram_wr_addr;
   tsbf_pkg::entry_type        ram_wr_data;
   logic                       ram_rd_en;
   logic [IDX_W-1:0]           ram_rd_addr;
   logic [tsbf_pkg::ENTRY_W-1:0] ram_rd_raw;
   tsbf_pkg::entry_type        rd_entry;

   // scan compare and command expiry
   logic                       entry_live;
   logic                       entry_match;
   logic [tsbf_pkg::TIME_W:0]  exp_sum;
   logic [tsbf_pkg::TIME_W-1:0] exp_sat;
   logic                       out_free;
   logic [CW-1:0]              count_wide;

   tsbf_ram #(
      .WIDTH (tsbf_pkg::ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign rd_entry    = tsbf_pkg::entry_type'(ram_rd_raw);
   assign entry_live  = valid_ff[idx_ff];
   assign entry_match = entry_live && (rd_entry.port == item_ff.in_port)
                        && (rd_entry.source == item_ff.src_ip);

   // new expiry, saturated to the time range
   assign exp_sum = {1'b0, item_ff.now} + (tsbf_pkg::TIME_W + 1)'(item_ff.duration);
   assign exp_sat = exp_sum[tsbf_pkg::TIME_W] ? '1 : exp_sum[tsbf_pkg::TIME_W-1:0];

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      drops_in      = drops_ff;
      rsp_valid_in  = rsp_valid_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      expired_in    = expired_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hit_ff ? hit_idx_ff : free_idx_ff;
      ram_wr_data.port   = item_ff.in_port;
      ram_wr_data.source = item_ff.src_ip;
      ram_wr_data.expiry = exp_sat;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;
      count_wide    = '0;

      // response register drains independently
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         tsbf_pkg::ST_IDLE: begin
            if (req_valid) begin
               item_in       = req_data;
               idx_in        = '0;
               hit_in        = 1'b0;
               expired_in    = 1'b0;
               free_found_in = 1'b0;
               if (req_data.op == tsbf_pkg::OP_BLOCK || req_data.is_ipv4) begin
                  ram_rd_en = 1'b1;
                  state_in  = tsbf_pkg::ST_SCAN;
               end else begin
                  state_in  = tsbf_pkg::ST_APPLY;
               end
            end
         end

         tsbf_pkg::ST_SCAN: begin
            if (entry_match) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
               expired_in = item_ff.now >= rd_entry.expiry;
               state_in   = tsbf_pkg::ST_APPLY;
            end else begin
               // remember the lowest free slot for an install
               if (!entry_live && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = tsbf_pkg::ST_APPLY;
               end else begin
                  idx_in      = idx_ff + IDX_W'(1);
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_ff + IDX_W'(1);
               end
            end
         end

         tsbf_pkg::ST_APPLY: begin
            if (out_free) begin
               rsp_in.drop       = 1'b0;
               rsp_in.lapsed     = 1'b0;
               rsp_in.installed  = 1'b0;
               rsp_in.table_full = 1'b0;
               if (item_ff.op == tsbf_pkg::OP_BLOCK) begin
                  if (hit_ff || free_found_ff) begin
                     ram_wr_en = 1'b1;
                     valid_in[ram_wr_addr] = 1'b1;
                     if (!hit_ff) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                     rsp_in.installed = 1'b1;
                  end else begin
                     rsp_in.table_full = 1'b1;
                  end
               end else if (item_ff.is_ipv4 && hit_ff) begin
                  if (expired_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                     count_in      = count_ff - CNT_W'(1);
                     rsp_in.lapsed = 1'b1;
                  end else begin
                     rsp_in.drop = 1'b1;
                     if (drops_ff != '1) begin
                        drops_in = drops_ff + tsbf_pkg::DROP_W'(1);
                     end
                  end
               end
               count_wide = CW'(count_in);
               rsp_in.active_entries = (count_wide > CW'(31)) ? 5'd31
                                       : count_wide[tsbf_pkg::ACTIVE_W-1:0];
               rsp_in.drop_count = drops_in;
               rsp_valid_in = 1'b1;
               state_in     = tsbf_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tsbf_pkg::ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsbf_pkg::ST_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         drops_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         drops_ff     <= drops_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      expired_ff    <= expired_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall = (state_ff != tsbf_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // entry count tracks the valid bits
   a_count_matches : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("entry count out of step with valid bits");

   // a response flags at most one outcome
   a_one_outcome : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_ff.drop, rsp_ff.lapsed,
                                 rsp_ff.installed, rsp_ff.table_full}))
      else $error("response carries more than one outcome");

   // refusal only when every slot is taken
   a_full_refusal : assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsbf_pkg::ST_APPLY && item_ff.op == tsbf_pkg::OP_BLOCK
       && !hit_ff && !free_found_ff) |-> (&valid_ff))
      else $error("command refused with a free slot");

   // drop counter never goes backwards
   a_drops_monotonic : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (drops_ff >= $past(drops_ff)))
      else $error("drop counter decreased");

endmodule

`default_nettype wire

// ===== verif/timed_source_block_filter_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// timed_source_block_filter_checker: result predictor and scoreboard
// Watches the request and response channels of the filter. Every accepted
// request beat is run through a local copy of the block table to work out
// the response it should cause. Response beats are compared field by field
// in order. The failure count and the number of responses still owed go
// back to the test top.
// -----------------------------------------------------------------------------
module timed_source_block_filter_checker
   import tsbf_pkg::*;
#(
   parameter int ENTRIES = DEF_TABLE_ENTRIES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      failures,
   output int      pending
);

   // local copy of the block table
   logic              held_valid  [ENTRIES];
   logic [PORT_W-1:0] held_port   [ENTRIES];
   logic [IP_W-1:0]   held_source [ENTRIES];
   logic [TIME_W-1:0] held_expiry [ENTRIES];
   logic [DROP_W-1:0] drop_total;

   rsp_type outcome_queue [$];
   int      fail_total;

   // Apply one request beat to the local table, return the response it causes
   function automatic rsp_type filter_outcome(req_type b);
      rsp_type         r;
      int              hit;
      int              slot;
      int              live;
      logic [TIME_W:0] reach;
      r    = '0;
      hit  = -1;
      slot = -1;
      live = 0;
      // lowest-indexed live match wins
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && held_valid[i] && held_port[i] == b.in_port &&
             held_source[i] == b.src_ip) begin
            hit = i;
         end
      end
      if (b.op == OP_BLOCK) begin
         // expiry saturates at the top of the time range
         reach = {1'b0, b.now} + {{(TIME_W + 1 - DUR_W){1'b0}}, b.duration};
         slot  = hit;
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !held_valid[i]) begin
               slot = i;
            end
         end
         if (slot >= 0) begin
            held_valid[slot]  = 1'b1;
            held_port[slot]   = b.in_port;
            held_source[slot] = b.src_ip;
            held_expiry[slot] = reach[TIME_W] ? '1 : reach[TIME_W-1:0];
            r.installed       = 1'b1;
         end else begin
            r.table_full = 1'b1;
         end
      end else if (b.is_ipv4) begin
         if (hit >= 0) begin
            if (b.now >= held_expiry[hit]) begin
               held_valid[hit] = 1'b0;
               r.lapsed        = 1'b1;
            end else begin
               r.drop = 1'b1;
               if (drop_total != '1) begin
                  drop_total = drop_total + 1'b1;
               end
            end
         end
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (held_valid[i]) begin
            live++;
         end
      end
      r.active_entries = (live > 31) ? 5'd31 : live[ACTIVE_W-1:0];
      r.drop_count     = drop_total;
      return r;
   endfunction

   // Scoreboard: responses first, since a beat taken at the same edge is newer
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            held_valid[i]  = 1'b0;
            held_port[i]   = '0;
            held_source[i] = '0;
            held_expiry[i] = '0;
         end
         drop_total = '0;
         outcome_queue.delete();
         fail_total = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_queue.size() == 0) begin
               if (fail_total < 10) begin
                  $display("%0t: response beat with none expected: %p", $realtime, rsp_data);
               end
               fail_total++;
            end else begin
               want = outcome_queue.pop_front();
               if (want.drop !== rsp_data.drop || want.lapsed !== rsp_data.lapsed ||
                   want.installed !== rsp_data.installed ||
                   want.table_full !== rsp_data.table_full ||
                   want.active_entries !== rsp_data.active_entries ||
                   want.drop_count !== rsp_data.drop_count) begin
                  if (fail_total < 10) begin
                     $display("%0t: mismatch, expected drop=%0b lapsed=%0b installed=%0b",
                              $realtime, want.drop, want.lapsed, want.installed,
                              " full=%0b active=%0d drops=%0d", want.table_full,
                              want.active_entries, want.drop_count);
                     $display("%0t:           actual drop=%0b lapsed=%0b installed=%0b",
                              $realtime, rsp_data.drop, rsp_data.lapsed, rsp_data.installed,
                              " full=%0b active=%0d drops=%0d", rsp_data.table_full,
                              rsp_data.active_entries, rsp_data.drop_count);
                  end
                  fail_total++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            outcome_queue = {outcome_queue, filter_outcome(req_data)};
         end
      end
      failures <= fail_total;
      pending  <= outcome_queue.size();
   end

endmodule

// ===== verif/timed_source_block_filter_test.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// timed_source_block_filter_test: stimulus and verdict for the filter
// Drives a directed opening (empty table, zero duration, expiry edges, full
// table, refresh and slot reuse), then epochs of random commands and frames
// over a small pool of address pairs with time jumping forward between
// epochs, and a closing sweep at the top of the time range. Both channels
// idle at random; the checker beside the block predicts and compares.
// -----------------------------------------------------------------------------
module timed_source_block_filter_test;
   import tsbf_pkg::*;

   localparam int                ENTRIES  = DEF_TABLE_ENTRIES;
   localparam int                POOL     = 24;
   localparam int                EPOCHS   = 9;
   localparam int                PER_EPOCH = 44;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   int      failures;
   int      pending;

   bit                steady;
   logic [TIME_W-1:0] tick;
   logic [PORT_W-1:0] pool_port [POOL];
   logic [IP_W-1:0]   pool_ip   [POOL];

   timed_source_block_filter #(
      .TABLE_ENTRIES (ENTRIES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   timed_source_block_filter_checker #(
      .ENTRIES (ENTRIES)
   ) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

   // Response side: stall a random number of cycles before each beat
   initial begin
      int hold;
      rsp_stall <= 1'b0;
      forever begin
         hold = steady ? 0 : $urandom_range(0, 3);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Present one request beat after a random gap, return once it is taken
   task automatic drive_beat(input req_type b);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_block(input logic [PORT_W-1:0] port, input logic [IP_W-1:0] ip,
                             input logic [DUR_W-1:0] dur);
      req_type b;
      b.op       = OP_BLOCK;
      b.now      = tick;
      b.in_port  = port;
      b.is_ipv4  = 1'($urandom_range(0, 1));
      b.src_ip   = ip;
      b.duration = dur;
      drive_beat(b);
   endtask

   task automatic send_frame(input logic ipv4, input logic [PORT_W-1:0] port,
                             input logic [IP_W-1:0] ip);
      req_type b;
      b.op       = OP_FRAME;
      b.now      = tick;
      b.in_port  = port;
      b.is_ipv4  = ipv4;
      b.src_ip   = ip;
      b.duration = $urandom;
      drive_beat(b);
   endtask

   // Hold the request side idle until every owed response has arrived
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin
      int               pick;
      int               sel;
      logic [63:0]      wide;
      logic [TIME_W-1:0] room;
      logic [DUR_W-1:0] dur;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      steady    = 1'b0;
      tick      = '0;
      for (int i = 0; i < POOL; i++) begin
         pool_port[i] = PORT_W'($urandom);
         pool_ip[i]   = $urandom;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty table, zero-duration block expires at once
      send_frame(1'b0, '0, '0);
      send_block('1, '1, '0);
      send_frame(1'b1, '1, '1);
      // drop while live, non-IPv4 passes, refresh shortens, expiry edges
      tick = 10;
      send_block('0, '0, 32'd100);
      tick = 50;
      send_frame(1'b1, '0, '0);
      send_frame(1'b0, '0, '0);
      tick = 60;
      send_block('0, '0, 32'd5);
      tick = 64;
      send_frame(1'b1, '0, '0);
      tick = 65;
      send_frame(1'b1, '0, '0);

      // fill the table, overflow it, refresh while full, reuse a freed slot
      tick = 100;
      for (int i = 0; i < ENTRIES; i++) begin
         send_block(pool_port[i], pool_ip[i], 32'd1000);
      end
      send_block(pool_port[ENTRIES], pool_ip[ENTRIES], 32'd1000);
      send_block(pool_port[3], pool_ip[3], 32'd2000);
      tick = 1500;
      send_frame(1'b1, pool_port[5], pool_ip[5]);
      send_block(pool_port[ENTRIES], pool_ip[ENTRIES], 32'd50);
      send_frame(1'b1, pool_port[ENTRIES], pool_ip[ENTRIES]);
      send_frame(1'b1, pool_port[3], pool_ip[3]);

      // random epochs; time jumps forward between them
      for (int e = 0; e < EPOCHS; e++) begin
         if (e % 3 == 0) begin
            drain();
         end
         steady = (e % 3 == 2);
         wide   = {$urandom, $urandom};
         room   = TIME_MAX - tick;
         tick   = tick + wide[TIME_W-1:0] % ((room >> 2) + 1);
         for (int n = 0; n < PER_EPOCH; n++) begin
            tick = tick + $urandom_range(0, 20);
            pick = $urandom_range(0, POOL - 1);
            sel  = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
               0:       dur = '0;
               1:       dur = $urandom;
               default: dur = $urandom_range(1, 80);
            endcase
            if (sel < 40) begin
               send_block(pool_port[pick], pool_ip[pick], dur);
            end else if (sel < 85) begin
               send_frame(1'b1, pool_port[pick], pool_ip[pick]);
            end else if (sel < 92) begin
               send_frame(1'b1, PORT_W'($urandom), $urandom);
            end else if (sel < 96) begin
               send_frame(1'b0, pool_port[pick], pool_ip[pick]);
            end else begin
               send_frame(1'b0, PORT_W'($urandom), $urandom);
            end
         end
      end
      steady = 1'b0;

      // top of the time range: sweep the pool, then saturated expiry
      tick = TIME_MAX - 20;
      for (int i = 0; i < POOL; i++) begin
         send_frame(1'b1, pool_port[i], pool_ip[i]);
      end
      send_block(pool_port[0], pool_ip[0], '1);
      send_frame(1'b1, pool_port[0], pool_ip[0]);
      send_block(pool_port[1], pool_ip[1], '0);
      tick = TIME_MAX;
      send_frame(1'b1, pool_port[0], pool_ip[0]);
      send_frame(1'b1, pool_port[1], pool_ip[1]);
      send_block(pool_port[2], pool_ip[2], '1);
      send_frame(1'b1, pool_port[2], pool_ip[2]);

      drain();
      repeat (ENTRIES + 8) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
